// ----- rtl/pbsd_pkg.sv -----
// ----------------------------------------------------------------------------
// pbsd_pkg
// Shared types, register map and helpers for the PackBits scanline decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pbsd_pkg;

    // Stream widths
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 24;
    localparam int unsigned M_TUSER_W = 1;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    typedef logic [2:0] cfg_index_t;
    localparam cfg_index_t REG_ROW_UNITS    = 3'd0;
    localparam cfg_index_t REG_ROW_TOTAL    = 3'd1;
    localparam cfg_index_t REG_PREFIX_BYTES = 3'd2;
    localparam cfg_index_t REG_WORD_MODE    = 3'd3;
    localparam cfg_index_t REG_TRIM_ODD     = 3'd4;

    // Decoder phases
    typedef logic [2:0] phase_t;
    localparam phase_t PH_START  = 3'd0;
    localparam phase_t PH_PREFIX = 3'd1;
    localparam phase_t PH_HEADER = 3'd2;
    localparam phase_t PH_RUN_HI = 3'd3;
    localparam phase_t PH_RUN_LO = 3'd4;
    localparam phase_t PH_LIT_HI = 3'd5;
    localparam phase_t PH_LIT_LO = 3'd6;
    localparam phase_t PH_DONE   = 3'd7;

    // Header codes
    localparam logic [7:0] HDR_NOP       = 8'h80;
    localparam logic [8:0] RUN_BASE      = 9'h101;
    localparam logic [7:0] MAX_REPEAT    = 8'h80;

    // Reset values of the registers
    localparam logic [15:0] ROW_UNITS_RST    = 16'd1;
    localparam logic [15:0] ROW_TOTAL_RST    = 16'd1;
    localparam logic [1:0]  PREFIX_BYTES_RST = 2'd2;

    // A 555 pixel widened to 565: green moves up one bit and gains a zero LSB.
    function automatic logic [15:0] widen_pixel(input logic [15:0] v);
        return {v[14:5], 1'b0, v[4:0]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/packbits_scanline_decoder_core.sv -----
// ----------------------------------------------------------------------------
// packbits_scanline_decoder_core
// Decodes a PackBits byte stream into (unit, repeat count) results per row.
// ----------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_*       in         tdata[7:0] data_byte
//  m_*       out        tdata[15:0] unit_value, tdata[23:16] repeat_count,
//                       tlast row_end, tuser[0] image_end
//  APB       in/out     registers row_units, row_total, prefix_bytes,
//                       word_mode, trim_odd at byte addresses 0x00 to 0x10
//
// One byte is accepted per cycle while the input register can take it;
// a byte that yields a result loads the result register once it is processed,
// from which its beat is offered; a full result register can delay processing.
// Synchronous reset on aresetn returns all but the data registers to defaults.
// A stalled result register holds the input side only once the input register
// is also full; otherwise bytes keep flowing.
`default_nettype none

module packbits_scanline_decoder_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input stream; tdata: [7:0] data_byte
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    input  wire logic [pbsd_pkg::S_TDATA_W-1:0]      s_tdata,
    // Result stream; tdata: [15:0] unit_value, [23:16] repeat_count
    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    output      logic [pbsd_pkg::M_TDATA_W-1:0]      m_tdata,
    output      logic                                m_tlast,
    // tuser: [0] image_end
    output      logic [pbsd_pkg::M_TUSER_W-1:0]      m_tuser,
    // Configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [pbsd_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [pbsd_pkg::APB_DATA_W-1:0]     pwdata,
    output      logic [pbsd_pkg::APB_DATA_W-1:0]     prdata,
    output      logic                                pready
);

    // Configuration registers
    logic [15:0] row_units_reg;
    logic [15:0] row_total_reg;
    logic [1:0]  prefix_bytes_reg;
    logic        word_mode_reg;
    logic        trim_odd_reg;

    logic                 cfg_write;
    pbsd_pkg::cfg_index_t cfg_index;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Decoder state
    pbsd_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  prefix_left_reg, prefix_left_next;
    logic [7:0]  literal_left_reg, literal_left_next;
    logic [7:0]  run_length_reg, run_length_next;
    logic [7:0]  high_byte_reg, high_byte_next;
    logic [16:0] column_count_reg, column_count_next;
    logic [15:0] row_index_reg, row_index_next;

    // Result register
    logic        out_valid_reg;
    logic [15:0] unit_value_reg;
    logic [7:0]  repeat_count_reg;
    logic        row_end_reg;
    logic        image_end_reg;

    logic        fire;
    logic        emit_req;
    logic        emit_close;
    logic [15:0] emit_value;
    logic [7:0]  emit_count;
    logic [7:0]  count_out;
    logic [16:0] col_sum;
    logic        row_done;
    logic        last_row;
    logic [7:0]  lit_dec;
    logic [15:0] word_pixel;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[pbsd_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_units_reg    <= pbsd_pkg::ROW_UNITS_RST;
            row_total_reg    <= pbsd_pkg::ROW_TOTAL_RST;
            prefix_bytes_reg <= pbsd_pkg::PREFIX_BYTES_RST;
            word_mode_reg    <= 1'b0;
            trim_odd_reg     <= 1'b0;
        end else if (cfg_write) begin
            case (cfg_index)
                pbsd_pkg::REG_ROW_UNITS:    row_units_reg    <= pwdata[15:0];
                pbsd_pkg::REG_ROW_TOTAL:    row_total_reg    <= pwdata[15:0];
                pbsd_pkg::REG_PREFIX_BYTES: prefix_bytes_reg <= pwdata[1:0];
                pbsd_pkg::REG_WORD_MODE:    word_mode_reg    <= pwdata[0];
                pbsd_pkg::REG_TRIM_ODD:     trim_odd_reg     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            pbsd_pkg::REG_ROW_UNITS:    prdata = {16'd0, row_units_reg};
            pbsd_pkg::REG_ROW_TOTAL:    prdata = {16'd0, row_total_reg};
            pbsd_pkg::REG_PREFIX_BYTES: prdata = {30'd0, prefix_bytes_reg};
            pbsd_pkg::REG_WORD_MODE:    prdata = {31'd0, word_mode_reg};
            pbsd_pkg::REG_TRIM_ODD:     prdata = {31'd0, trim_odd_reg};
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Handshake: the held byte is processed once the result register is free
    // or being emptied in the same cycle.
    // ------------------------------------------------------------------------
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    // ------------------------------------------------------------------------
    // Byte decode
    // ------------------------------------------------------------------------
    assign lit_dec    = literal_left_reg - 8'd1;
    assign word_pixel = pbsd_pkg::widen_pixel({high_byte_reg, in_byte_reg});

    always_comb begin
        phase_next        = phase_reg;
        prefix_left_next  = prefix_left_reg;
        literal_left_next = literal_left_reg;
        run_length_next   = run_length_reg;
        high_byte_next    = high_byte_reg;
        emit_req          = 1'b0;
        emit_close        = 1'b0;
        emit_value        = {8'd0, in_byte_reg};
        emit_count        = 8'd1;

        case (phase_reg)
            pbsd_pkg::PH_START: begin
                if (prefix_bytes_reg != 2'd0) begin
                    prefix_left_next = prefix_bytes_reg - 2'd1;
                    phase_next = (prefix_bytes_reg == 2'd1) ? pbsd_pkg::PH_HEADER
                                                            : pbsd_pkg::PH_PREFIX;
                end else if (in_byte_reg == pbsd_pkg::HDR_NOP) begin
                    phase_next = pbsd_pkg::PH_HEADER;
                end else if (in_byte_reg[7]) begin
                    run_length_next = 8'(pbsd_pkg::RUN_BASE - {1'b0, in_byte_reg});
                    phase_next      = pbsd_pkg::PH_RUN_HI;
                end else begin
                    literal_left_next = in_byte_reg + 8'd1;
                    phase_next        = pbsd_pkg::PH_LIT_HI;
                end
            end
            pbsd_pkg::PH_PREFIX: begin
                prefix_left_next = prefix_left_reg - 2'd1;
                if (prefix_left_reg == 2'd1) begin
                    phase_next = pbsd_pkg::PH_HEADER;
                end
            end
            pbsd_pkg::PH_HEADER: begin
                if (in_byte_reg == pbsd_pkg::HDR_NOP) begin
                    phase_next = pbsd_pkg::PH_HEADER;
                end else if (in_byte_reg[7]) begin
                    run_length_next = 8'(pbsd_pkg::RUN_BASE - {1'b0, in_byte_reg});
                    phase_next      = pbsd_pkg::PH_RUN_HI;
                end else begin
                    literal_left_next = in_byte_reg + 8'd1;
                    phase_next        = pbsd_pkg::PH_LIT_HI;
                end
            end
            pbsd_pkg::PH_RUN_HI: begin
                if (word_mode_reg) begin
                    high_byte_next = in_byte_reg;
                    phase_next     = pbsd_pkg::PH_RUN_LO;
                end else begin
                    emit_req   = 1'b1;
                    emit_close = 1'b1;
                    emit_count = run_length_reg;
                end
            end
            pbsd_pkg::PH_RUN_LO: begin
                emit_req   = 1'b1;
                emit_close = 1'b1;
                emit_value = word_pixel;
                emit_count = run_length_reg;
            end
            pbsd_pkg::PH_LIT_HI: begin
                if (word_mode_reg) begin
                    high_byte_next = in_byte_reg;
                    phase_next     = pbsd_pkg::PH_LIT_LO;
                end else begin
                    literal_left_next = lit_dec;
                    emit_req          = 1'b1;
                    emit_close        = (lit_dec == 8'd0);
                end
            end
            pbsd_pkg::PH_LIT_LO: begin
                literal_left_next = lit_dec;
                phase_next        = pbsd_pkg::PH_LIT_HI;
                emit_req          = 1'b1;
                emit_close        = (lit_dec == 8'd0);
                emit_value        = word_pixel;
            end
            default: ;
        endcase
    end

    // Row and image accounting for an emitted unit.
    assign col_sum   = column_count_reg + {9'd0, emit_count};
    assign row_done  = emit_close && (col_sum >= {1'b0, row_units_reg});
    assign last_row  = ({1'b0, row_index_reg} + 17'd1) >= {1'b0, row_total_reg};
    assign count_out = (trim_odd_reg && row_done && emit_count != 8'd0)
                       ? emit_count - 8'd1 : emit_count;

    always_comb begin
        column_count_next = column_count_reg;
        row_index_next    = row_index_reg;
        if (emit_req) begin
            column_count_next = col_sum;
            if (row_done) begin
                column_count_next = '0;
                if (!last_row) begin
                    row_index_next = row_index_reg + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= pbsd_pkg::PH_START;
            prefix_left_reg  <= pbsd_pkg::PREFIX_BYTES_RST;
            literal_left_reg <= '0;
            run_length_reg   <= '0;
            high_byte_reg    <= '0;
            column_count_reg <= '0;
            row_index_reg    <= '0;
        end else if (fire) begin
            prefix_left_reg  <= prefix_left_next;
            literal_left_reg <= literal_left_next;
            run_length_reg   <= run_length_next;
            high_byte_reg    <= high_byte_next;
            column_count_reg <= column_count_next;
            row_index_reg    <= row_index_next;
            if (emit_req && row_done) begin
                phase_reg <= last_row ? pbsd_pkg::PH_DONE : pbsd_pkg::PH_START;
            end else if (emit_req && emit_close) begin
                phase_reg <= pbsd_pkg::PH_HEADER;
            end else begin
                phase_reg <= phase_next;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && emit_req) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit_req) begin
            unit_value_reg   <= emit_value;
            repeat_count_reg <= count_out;
            row_end_reg      <= row_done;
            image_end_reg    <= row_done && last_row;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {repeat_count_reg, unit_value_reg};
    assign m_tlast  = row_end_reg;
    assign m_tuser  = image_end_reg;

endmodule

`default_nettype wire

// ----- rtl/pbsd_checker.sv -----
// ----------------------------------------------------------------------------
// pbsd_checker
// Port-level checks on the PackBits scanline decoder, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pbsd_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [pbsd_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic                            m_tlast,
    input wire logic [pbsd_pkg::M_TUSER_W-1:0]  m_tuser,
    input wire logic                            pready
);

    // A result waiting on the far side must hold still.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                   && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // The end of the image is always also the end of a row.
    a_image_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("image end without row end");

    // No run is longer than the longest repeat header allows.
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[23:16] <= pbsd_pkg::MAX_REPEAT)
        else $error("repeat count out of range");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind packbits_scanline_decoder_core pbsd_checker u_pbsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

`default_nettype wire
